>>> rtl/assert_macros.svh
// Assertion macros used by the checker file acm_checker.sv.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ACM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acm check failed");

// Next-cycle implication
`define ACM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acm check failed");

`endif

>>> rtl/acm_pkg.sv
// Package for the multi-pattern first/last matcher: sizes, op codes,
// controller states and the transaction structs. No dependencies.
`default_nettype none

package acm_pkg;

  // Fixed sizes
  localparam int ALPHABET     = 26;
  localparam int MAX_NODES    = 256;
  localparam int MAX_PATTERNS = 32;
  localparam int POS_BITS     = 20;
  localparam int NODE_W       = 8;
  localparam int GOTO_DEPTH   = MAX_NODES * ALPHABET;
  localparam int GOTO_AW      = 13;
  localparam logic [4:0] REPORT_SYM = 5'd26;

  // Op codes
  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_PAT_LETTER = 3'd1,
    OP_PAT_CLOSE  = 3'd2,
    OP_BUILD      = 3'd3,
    OP_TEXT       = 3'd4
  } acm_op_e;

  // Controller states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_WB,
    ST_BR_RD,
    ST_BR_CHK,
    ST_BN_ORD,
    ST_BN_SL,
    ST_BN_RD,
    ST_BN_CHK,
    ST_TX_WB,
    ST_RP_ORD,
    ST_RP_SL,
    ST_RP_FL,
    ST_RP_WB,
    ST_OUT_RD,
    ST_OUT_FL,
    ST_OUT_EMIT
  } acm_state_e;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] symbol;
  } acm_cmd_t;

  typedef struct packed {
    logic [4:0]  pattern_index;
    logic        found;
    logic [20:0] first_start;
    logic [20:0] last_start;
    logic        overflow;
    logic        last_of_run;
  } acm_result_t;

  // Request to the first/last position store
  typedef struct packed {
    logic                rd_en;
    logic [NODE_W-1:0]   rd_a;
    logic [NODE_W-1:0]   rd_b;
    logic                wr_en;
    logic [NODE_W-1:0]   wr_addr;
    logic                wr_first_en;
    logic                first_if_new;
    logic [POS_BITS-1:0] wr_first;
    logic                wr_last_en;
    logic [POS_BITS-1:0] wr_last;
    logic                set_seen;
    logic                clr_seen;
  } acm_pos_req_t;

  // Registered read data of both store ports
  typedef struct packed {
    logic                a_seen;
    logic [POS_BITS-1:0] a_first;
    logic [POS_BITS-1:0] a_last;
    logic                b_seen;
    logic [POS_BITS-1:0] b_first;
    logic [POS_BITS-1:0] b_last;
  } acm_pos_rsp_t;

  // Goto table address of (node, letter)
  function automatic logic [GOTO_AW-1:0] goto_addr(input logic [NODE_W-1:0] node,
                                                   input logic [4:0] letter);
    return GOTO_AW'({5'd0, node} * 13'd26 + {8'd0, letter});
  endfunction

endpackage

`default_nettype wire

>>> rtl/acm_pos_store.sv
// First/last end position store: two-read, one-write memory per node plus
// per-node seen flags. Depends on acm_pkg.
`default_nettype none

module acm_pos_store (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire acm_pkg::acm_pos_req_t req_i,
  output acm_pkg::acm_pos_rsp_t      rsp_o
);

  logic [acm_pkg::POS_BITS-1:0] first_mem [acm_pkg::MAX_NODES];
  logic [acm_pkg::POS_BITS-1:0] last_mem  [acm_pkg::MAX_NODES];
  logic [acm_pkg::MAX_NODES-1:0] seen_q;
  logic do_first;

  // first is written only for a node not seen yet when first_if_new is set
  assign do_first = req_i.wr_en && req_i.wr_first_en &&
                    (!req_i.first_if_new || !seen_q[req_i.wr_addr]);

  // Seen flags: the root starts as seen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= {{(acm_pkg::MAX_NODES-1){1'b0}}, 1'b1};
    end else if (req_i.clr_seen) begin
      seen_q <= {{(acm_pkg::MAX_NODES-1){1'b0}}, 1'b1};
    end else if (req_i.wr_en && req_i.set_seen) begin
      seen_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // Memory write and registered reads
  always_ff @(posedge clk_i) begin
    if (do_first) first_mem[req_i.wr_addr] <= req_i.wr_first;
    if (req_i.wr_en && req_i.wr_last_en) last_mem[req_i.wr_addr] <= req_i.wr_last;
    if (req_i.rd_en) begin
      rsp_o.a_seen  <= seen_q[req_i.rd_a];
      rsp_o.a_first <= first_mem[req_i.rd_a];
      rsp_o.a_last  <= last_mem[req_i.rd_a];
      rsp_o.b_seen  <= seen_q[req_i.rd_b];
      rsp_o.b_first <= first_mem[req_i.rd_b];
      rsp_o.b_last  <= last_mem[req_i.rd_b];
    end
  end

endmodule

`default_nettype wire

>>> rtl/multi_pattern_first_last_matcher_core.sv
// Top level of the Aho-Corasick first/last matcher: op sequencer with the
// goto, suffix link, breadth order and pattern memories. Uses acm_pkg, acm_pos_store.
`default_nettype none

// Usage
//   A command transaction (op, symbol) is taken when start is high and busy
//   is low. Ops: clear, pattern letter, close pattern, build, text letter
//   (symbol 26 with the text op asks for a report).
//   Op steps: close and misordered ops end in the decode; pattern letter and
//   text letter do one goto table read, then the write back; build reads
//   and checks each (node, letter) pair, after breadth order and suffix
//   link reads per node; report does the suffix link merge per trie node,
//   then reads out each loaded pattern, each result shown on result_o for
//   one cycle with result_valid_o high, last_of_run marking the final one.
//   Reset and clear both run a pass over the 6656-entry goto table, one
//   entry a cycle, with busy high; the position store's seen flags clear
//   at once. The receiver cannot stall: results are never held back.
//   overflow is a sticky error flag cleared only by reset or clear.

module multi_pattern_first_last_matcher_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire acm_pkg::acm_cmd_t    cmd_i,
  output logic                      result_valid_o,
  output acm_pkg::acm_result_t      result_o
);

  localparam int AW = acm_pkg::GOTO_AW;
  localparam int NW = acm_pkg::NODE_W;

  acm_pkg::acm_state_e state_q, state_d;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [NW-1:0] cursor_q, cursor_d;
  logic [8:0]    len_q, len_d;
  logic [8:0]    nc_q, nc_d;
  logic [5:0]    pc_q, pc_d;
  logic [NW-1:0] scan_q, scan_d;
  logic [20:0]   pos_q, pos_d;
  logic          built_q, built_d;
  logic          err_q, err_d;
  logic [4:0]    sym_q, sym_d;
  logic [4:0]    c_q, c_d;
  logic [8:0]    head_q, head_d;
  logic [8:0]    tail_q, tail_d;
  logic [NW-1:0] u_q, u_d;
  logic [8:0]    idx_q, idx_d;
  logic [NW-1:0] node_q, node_d;
  logic [NW-1:0] dst_q, dst_d;
  logic [5:0]    j_q, j_d;

  // Goto table
  logic [NW-1:0] goto_mem [acm_pkg::GOTO_DEPTH];
  logic          g_we, g_rea, g_reb;
  logic [AW-1:0] g_wa, g_ra, g_rb;
  logic [NW-1:0] g_wd, ga_rdata_q, gb_rdata_q;

  // Suffix links and breadth order
  logic [NW-1:0] sl_mem  [acm_pkg::MAX_NODES];
  logic [NW-1:0] ord_mem [acm_pkg::MAX_NODES];
  logic          sl_we, sl_re, ord_we, ord_re;
  logic [NW-1:0] sl_wa, sl_wd, sl_ra, sl_rdata_q;
  logic [NW-1:0] ord_wa, ord_wd, ord_ra, ord_rdata_q;

  // Pattern end node and length
  logic [NW-1:0] pend_mem [acm_pkg::MAX_PATTERNS];
  logic [8:0]    plen_mem [acm_pkg::MAX_PATTERNS];
  logic          pat_we, pat_re;
  logic [4:0]    pat_wa, pat_ra;
  logic [NW-1:0] pend_rdata_q;
  logic [8:0]    plen_rdata_q;

  acm_pkg::acm_pos_req_t pos_req;
  acm_pkg::acm_pos_rsp_t pos_rsp;

  acm_pos_store u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pos_req),
    .rsp_o  (pos_rsp)
  );

  // Memories
  always_ff @(posedge clk_i) begin
    if (g_we)   goto_mem[g_wa] <= g_wd;
    if (g_rea)  ga_rdata_q <= goto_mem[g_ra];
    if (g_reb)  gb_rdata_q <= goto_mem[g_rb];
    if (sl_we)  sl_mem[sl_wa] <= sl_wd;
    if (sl_re)  sl_rdata_q <= sl_mem[sl_ra];
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rdata_q <= ord_mem[ord_ra];
    if (pat_we) begin
      pend_mem[pat_wa] <= cursor_q;
      plen_mem[pat_wa] <= len_q;
    end
    if (pat_re) begin
      pend_rdata_q <= pend_mem[pat_ra];
      plen_rdata_q <= plen_mem[pat_ra];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= acm_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      cursor_q  <= '0;
      len_q     <= '0;
      nc_q      <= 9'd1;
      pc_q      <= '0;
      scan_q    <= '0;
      pos_q     <= '0;
      built_q   <= 1'b0;
      err_q     <= 1'b0;
      sym_q     <= '0;
      c_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      u_q       <= '0;
      idx_q     <= '0;
      node_q    <= '0;
      dst_q     <= '0;
      j_q       <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cursor_q  <= cursor_d;
      len_q     <= len_d;
      nc_q      <= nc_d;
      pc_q      <= pc_d;
      scan_q    <= scan_d;
      pos_q     <= pos_d;
      built_q   <= built_d;
      err_q     <= err_d;
      sym_q     <= sym_d;
      c_q       <= c_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      u_q       <= u_d;
      idx_q     <= idx_d;
      node_q    <= node_d;
      dst_q     <= dst_d;
      j_q       <= j_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    cursor_d  = cursor_q;
    len_d     = len_q;
    nc_d      = nc_q;
    pc_d      = pc_q;
    scan_d    = scan_q;
    pos_d     = pos_q;
    built_d   = built_q;
    err_d     = err_q;
    sym_d     = sym_q;
    c_d       = c_q;
    head_d    = head_q;
    tail_d    = tail_q;
    u_d       = u_q;
    idx_d     = idx_q;
    node_d    = node_q;
    dst_d     = dst_q;
    j_d       = j_q;

    g_we  = 1'b0;  g_wa = '0;  g_wd = '0;
    g_rea = 1'b0;  g_ra = '0;
    g_reb = 1'b0;  g_rb = '0;
    sl_we = 1'b0;  sl_wa = '0; sl_wd = '0;
    sl_re = 1'b0;  sl_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    ord_re = 1'b0; ord_ra = '0;
    pat_we = 1'b0; pat_wa = '0;
    pat_re = 1'b0; pat_ra = '0;
    pos_req = '0;

    result_valid_o = 1'b0;
    result_o       = '0;

    case (state_q)
      // Clearing pass over the goto table; root positions set to zero
      acm_pkg::ST_CLEAR: begin
        g_we = 1'b1;
        g_wa = clr_cnt_q;
        if (clr_cnt_q == '0) begin
          pos_req.wr_en       = 1'b1;
          pos_req.wr_addr     = '0;
          pos_req.wr_first_en = 1'b1;
          pos_req.wr_last_en  = 1'b1;
        end
        if (clr_cnt_q == AW'(acm_pkg::GOTO_DEPTH - 1)) begin
          state_d = acm_pkg::ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      // Command decode
      acm_pkg::ST_IDLE: begin
        if (start) begin
          sym_d = cmd_i.symbol;
          case (cmd_i.op)
            acm_pkg::OP_CLEAR: begin
              clr_cnt_d = '0;
              cursor_d  = '0;
              len_d     = '0;
              nc_d      = 9'd1;
              pc_d      = '0;
              scan_d    = '0;
              pos_d     = '0;
              built_d   = 1'b0;
              err_d     = 1'b0;
              pos_req.clr_seen = 1'b1;
              state_d   = acm_pkg::ST_CLEAR;
            end
            acm_pkg::OP_PAT_LETTER: begin
              if (built_q || cmd_i.symbol >= 5'(acm_pkg::ALPHABET)) begin
                err_d = 1'b1;
              end else begin
                g_rea   = 1'b1;
                g_ra    = acm_pkg::goto_addr(cursor_q, cmd_i.symbol);
                state_d = acm_pkg::ST_INS_WB;
              end
            end
            acm_pkg::OP_PAT_CLOSE: begin
              if (built_q) begin
                err_d = 1'b1;
              end else begin
                if (pc_q >= 6'(acm_pkg::MAX_PATTERNS)) begin
                  err_d = 1'b1;
                end else begin
                  pat_we = 1'b1;
                  pat_wa = pc_q[4:0];
                  pc_d   = pc_q + 1'b1;
                end
                cursor_d = '0;
                len_d    = '0;
              end
            end
            acm_pkg::OP_BUILD: begin
              if (built_q) begin
                err_d = 1'b1;
              end else begin
                cursor_d = '0;
                len_d    = '0;
                c_d      = '0;
                tail_d   = '0;
                head_d   = '0;
                state_d  = acm_pkg::ST_BR_RD;
              end
            end
            acm_pkg::OP_TEXT: begin
              if (!built_q || cmd_i.symbol > acm_pkg::REPORT_SYM) begin
                err_d = 1'b1;
              end else if (cmd_i.symbol != acm_pkg::REPORT_SYM) begin
                if (pos_q[acm_pkg::POS_BITS]) begin
                  err_d = 1'b1;
                end else begin
                  g_rea   = 1'b1;
                  g_ra    = acm_pkg::goto_addr(scan_q, cmd_i.symbol);
                  state_d = acm_pkg::ST_TX_WB;
                end
              end else begin
                idx_d   = nc_q - 1'b1;
                j_d     = '0;
                state_d = (nc_q == 9'd1) ? acm_pkg::ST_OUT_RD : acm_pkg::ST_RP_ORD;
              end
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
        end
      end

      // Pattern letter: follow or create the child
      acm_pkg::ST_INS_WB: begin
        state_d = acm_pkg::ST_IDLE;
        if (ga_rdata_q == '0) begin
          if (nc_q >= 9'(acm_pkg::MAX_NODES)) begin
            err_d = 1'b1;
          end else begin
            g_we     = 1'b1;
            g_wa     = acm_pkg::goto_addr(cursor_q, sym_q);
            g_wd     = nc_q[NW-1:0];
            cursor_d = nc_q[NW-1:0];
            nc_d     = nc_q + 1'b1;
            len_d    = len_q + 1'b1;
          end
        end else begin
          cursor_d = ga_rdata_q;
          len_d    = len_q + 1'b1;
        end
      end

      // Build: root children get link to root
      acm_pkg::ST_BR_RD: begin
        g_rea   = 1'b1;
        g_ra    = AW'(c_q);
        state_d = acm_pkg::ST_BR_CHK;
      end

      acm_pkg::ST_BR_CHK: begin
        if (ga_rdata_q != '0) begin
          sl_we  = 1'b1;
          sl_wa  = ga_rdata_q;
          sl_wd  = '0;
          ord_we = 1'b1;
          ord_wa = tail_q[NW-1:0];
          ord_wd = ga_rdata_q;
          tail_d = tail_q + 1'b1;
        end
        if (c_q == 5'(acm_pkg::ALPHABET - 1)) begin
          state_d = acm_pkg::ST_BN_ORD;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = acm_pkg::ST_BR_RD;
        end
      end

      // Build: next node in breadth order
      acm_pkg::ST_BN_ORD: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
          state_d = acm_pkg::ST_IDLE;
        end else begin
          ord_re  = 1'b1;
          ord_ra  = head_q[NW-1:0];
          state_d = acm_pkg::ST_BN_SL;
        end
      end

      acm_pkg::ST_BN_SL: begin
        u_d     = ord_rdata_q;
        sl_re   = 1'b1;
        sl_ra   = ord_rdata_q;
        c_d     = '0;
        state_d = acm_pkg::ST_BN_RD;
      end

      // Build: read own entry and the suffix link's entry
      acm_pkg::ST_BN_RD: begin
        g_rea   = 1'b1;
        g_ra    = acm_pkg::goto_addr(u_q, c_q);
        g_reb   = 1'b1;
        g_rb    = acm_pkg::goto_addr(sl_rdata_q, c_q);
        state_d = acm_pkg::ST_BN_CHK;
      end

      acm_pkg::ST_BN_CHK: begin
        if (ga_rdata_q != '0) begin
          sl_we  = 1'b1;
          sl_wa  = ga_rdata_q;
          sl_wd  = gb_rdata_q;
          ord_we = 1'b1;
          ord_wa = tail_q[NW-1:0];
          ord_wd = ga_rdata_q;
          tail_d = tail_q + 1'b1;
        end else begin
          g_we = 1'b1;
          g_wa = acm_pkg::goto_addr(u_q, c_q);
          g_wd = gb_rdata_q;
        end
        if (c_q == 5'(acm_pkg::ALPHABET - 1)) begin
          head_d  = head_q + 1'b1;
          state_d = acm_pkg::ST_BN_ORD;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = acm_pkg::ST_BN_RD;
        end
      end

      // Text letter: move and record positions
      acm_pkg::ST_TX_WB: begin
        scan_d               = ga_rdata_q;
        pos_req.wr_en        = 1'b1;
        pos_req.wr_addr      = ga_rdata_q;
        pos_req.wr_first_en  = 1'b1;
        pos_req.first_if_new = 1'b1;
        pos_req.wr_first     = pos_q[acm_pkg::POS_BITS-1:0];
        pos_req.wr_last_en   = 1'b1;
        pos_req.wr_last      = pos_q[acm_pkg::POS_BITS-1:0];
        pos_req.set_seen     = 1'b1;
        pos_d                = pos_q + 1'b1;
        state_d              = acm_pkg::ST_IDLE;
      end

      // Report: merge along suffix links in reverse breadth order
      acm_pkg::ST_RP_ORD: begin
        ord_re  = 1'b1;
        ord_ra  = NW'(idx_q - 1'b1);
        state_d = acm_pkg::ST_RP_SL;
      end

      acm_pkg::ST_RP_SL: begin
        node_d  = ord_rdata_q;
        sl_re   = 1'b1;
        sl_ra   = ord_rdata_q;
        state_d = acm_pkg::ST_RP_FL;
      end

      acm_pkg::ST_RP_FL: begin
        dst_d        = sl_rdata_q;
        pos_req.rd_en = 1'b1;
        pos_req.rd_a  = node_q;
        pos_req.rd_b  = sl_rdata_q;
        state_d      = acm_pkg::ST_RP_WB;
      end

      acm_pkg::ST_RP_WB: begin
        if (pos_rsp.a_seen) begin
          pos_req.wr_en       = 1'b1;
          pos_req.wr_addr     = dst_q;
          pos_req.wr_first_en = 1'b1;
          pos_req.wr_last_en  = 1'b1;
          pos_req.set_seen    = 1'b1;
          pos_req.wr_first    = (pos_rsp.b_seen && pos_rsp.b_first < pos_rsp.a_first)
                                ? pos_rsp.b_first : pos_rsp.a_first;
          pos_req.wr_last     = (pos_rsp.b_seen && pos_rsp.b_last > pos_rsp.a_last)
                                ? pos_rsp.b_last : pos_rsp.a_last;
        end
        idx_d   = idx_q - 1'b1;
        state_d = (idx_q == 9'd1) ? acm_pkg::ST_OUT_RD : acm_pkg::ST_RP_ORD;
      end

      // Report: one result per pattern
      acm_pkg::ST_OUT_RD: begin
        if (j_q == pc_q) begin
          state_d = acm_pkg::ST_IDLE;
        end else begin
          pat_re  = 1'b1;
          pat_ra  = j_q[4:0];
          state_d = acm_pkg::ST_OUT_FL;
        end
      end

      acm_pkg::ST_OUT_FL: begin
        pos_req.rd_en = 1'b1;
        pos_req.rd_a  = pend_rdata_q;
        pos_req.rd_b  = pend_rdata_q;
        state_d       = acm_pkg::ST_OUT_EMIT;
      end

      acm_pkg::ST_OUT_EMIT: begin
        result_valid_o          = 1'b1;
        result_o.pattern_index  = j_q[4:0];
        result_o.found          = pos_rsp.a_seen;
        if (pos_rsp.a_seen) begin
          result_o.first_start = {1'b0, pos_rsp.a_first} - {12'd0, plen_rdata_q} + 21'd1;
          result_o.last_start  = {1'b0, pos_rsp.a_last} - {12'd0, plen_rdata_q} + 21'd1;
        end
        result_o.overflow       = err_q;
        result_o.last_of_run    = ((j_q + 1'b1) == pc_q);
        j_d                     = j_q + 1'b1;
        state_d                 = acm_pkg::ST_OUT_RD;
      end

      default: begin
        state_d = acm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != acm_pkg::ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/acm_checker.sv
// Port-level checks for the matcher core, bound to the top level.
// Uses acm_pkg and the macros in assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module acm_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire acm_pkg::acm_cmd_t    cmd_i,
  input wire logic                 result_valid_o,
  input wire acm_pkg::acm_result_t result_o
);

  // results only come out during a report transaction
  `ACM_ASSERT_IMPL(a_result_busy, result_valid_o, busy)

  // a clear always starts the table sweep
  `ACM_ASSERT_NEXT(a_clear_busy, start && !busy && cmd_i.op == acm_pkg::OP_CLEAR, busy)

  // nothing follows the final result of a run
  `ACM_ASSERT_NEXT(a_last_ends, result_valid_o && result_o.last_of_run, !result_valid_o)

  // not-found results carry zero starts
  `ACM_ASSERT_IMPL(a_notfound_zero, result_valid_o && !result_o.found,
                   result_o.first_start == '0 && result_o.last_start == '0)

endmodule

bind multi_pattern_first_last_matcher_core acm_checker u_acm_checker (.*);

`default_nettype wire

>>> verif/multi_pattern_first_last_matcher_core_checker.sv
// Checker for the multi-pattern first/last matcher: watches command and result
// transactions, predicts results with its own Aho-Corasick model, compares.
// Depends on acm_pkg.
`timescale 1ns / 100ps

module multi_pattern_first_last_matcher_core_checker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire acm_pkg::acm_cmd_t    cmd_i,
  input  wire logic                 result_valid_o,
  input  wire acm_pkg::acm_result_t result_o,
  output int                        errors,
  output int                        pending
);

  // Matcher state mirror
  logic [7:0] trie_goto [0:acm_pkg::GOTO_DEPTH-1];
  logic [7:0] fail_link [0:acm_pkg::MAX_NODES-1];
  logic [7:0] bfs_order [0:acm_pkg::MAX_NODES-1];
  longint     first_end [0:acm_pkg::MAX_NODES-1];
  longint     last_end  [0:acm_pkg::MAX_NODES-1];
  bit         end_seen  [0:acm_pkg::MAX_NODES-1];
  int         pat_node  [0:acm_pkg::MAX_PATTERNS-1];
  int         pat_len   [0:acm_pkg::MAX_PATTERNS-1];
  int         node_cnt, pat_cnt, ins_node, ins_len, scan_node;
  longint     text_pos;
  bit         built, sticky_err;

  acm_pkg::acm_result_t expected_results[$];

  task automatic clear_matcher();
    for (int k = 0; k < acm_pkg::GOTO_DEPTH; k++) trie_goto[k] = '0;
    for (int k = 0; k < acm_pkg::MAX_NODES; k++) begin
      fail_link[k] = '0;
      bfs_order[k] = '0;
      first_end[k] = 0;
      last_end[k]  = 0;
      end_seen[k]  = 1'b0;
    end
    end_seen[0] = 1'b1;
    node_cnt   = 1;
    pat_cnt    = 0;
    ins_node   = 0;
    ins_len    = 0;
    scan_node  = 0;
    text_pos   = 0;
    built      = 1'b0;
    sticky_err = 1'b0;
  endtask

  // Breadth-first pass: suffix links and goto completion
  task automatic build_automaton();
    int head, tail, u, v, fill;
    head = 0;
    tail = 0;
    for (int c = 0; c < acm_pkg::ALPHABET; c++) begin
      v = trie_goto[c];
      if (v != 0 && tail < acm_pkg::MAX_NODES) begin
        fail_link[v] = '0;
        bfs_order[tail++] = 8'(v);
      end
    end
    while (head < tail) begin
      u = bfs_order[head++];
      for (int c = 0; c < acm_pkg::ALPHABET; c++) begin
        v    = trie_goto[u * acm_pkg::ALPHABET + c];
        fill = trie_goto[fail_link[u] * acm_pkg::ALPHABET + c];
        if (v != 0) begin
          fail_link[v] = 8'(fill);
          if (tail < acm_pkg::MAX_NODES) bfs_order[tail++] = 8'(v);
        end else begin
          trie_goto[u * acm_pkg::ALPHABET + c] = 8'(fill);
        end
      end
    end
  endtask

  task automatic merge_positions(input int dst, input int src);
    if (!end_seen[src]) return;
    if (!end_seen[dst]) begin
      end_seen[dst]  = 1'b1;
      first_end[dst] = first_end[src];
      last_end[dst]  = last_end[src];
    end else begin
      if (first_end[src] < first_end[dst]) first_end[dst] = first_end[src];
      if (last_end[src] > last_end[dst]) last_end[dst] = last_end[src];
    end
  endtask

  // Propagate along suffix links, then queue one result per pattern
  task automatic report_matches();
    int node;
    acm_pkg::acm_result_t r;
    for (int i = node_cnt - 1; i > 0; i--) begin
      node = bfs_order[i-1];
      merge_positions(fail_link[node], node);
    end
    for (int i = 0; i < pat_cnt; i++) begin
      node = pat_node[i];
      r.pattern_index = 5'(i);
      r.found         = end_seen[node];
      r.first_start   = end_seen[node] ? 21'(first_end[node] - pat_len[i] + 1) : '0;
      r.last_start    = end_seen[node] ? 21'(last_end[node] - pat_len[i] + 1) : '0;
      r.overflow      = sticky_err;
      r.last_of_run   = (i + 1 == pat_cnt);
      expected_results = {expected_results, r};
    end
  endtask

  task automatic apply_command(input acm_pkg::acm_cmd_t c);
    int k;
    case (c.op)
      acm_pkg::OP_CLEAR: clear_matcher();
      acm_pkg::OP_PAT_LETTER: begin
        if (built || c.symbol >= acm_pkg::ALPHABET) begin
          sticky_err = 1'b1;
        end else begin
          k = ins_node * acm_pkg::ALPHABET + c.symbol;
          if (trie_goto[k] == 0 && node_cnt >= acm_pkg::MAX_NODES) begin
            sticky_err = 1'b1;
          end else begin
            if (trie_goto[k] == 0) trie_goto[k] = 8'(node_cnt++);
            ins_node = trie_goto[k];
            ins_len++;
          end
        end
      end
      acm_pkg::OP_PAT_CLOSE: begin
        if (built) begin
          sticky_err = 1'b1;
        end else begin
          if (pat_cnt >= acm_pkg::MAX_PATTERNS) begin
            sticky_err = 1'b1;
          end else begin
            pat_node[pat_cnt] = ins_node;
            pat_len[pat_cnt]  = ins_len;
            pat_cnt++;
          end
          ins_node = 0;
          ins_len  = 0;
        end
      end
      acm_pkg::OP_BUILD: begin
        if (built) begin
          sticky_err = 1'b1;
        end else begin
          build_automaton();
          built    = 1'b1;
          ins_node = 0;
          ins_len  = 0;
        end
      end
      acm_pkg::OP_TEXT: begin
        if (!built || c.symbol > acm_pkg::REPORT_SYM) begin
          sticky_err = 1'b1;
        end else if (c.symbol == acm_pkg::REPORT_SYM) begin
          report_matches();
        end else if (text_pos >= (64'd1 << acm_pkg::POS_BITS)) begin
          sticky_err = 1'b1;
        end else begin
          scan_node = trie_goto[scan_node * acm_pkg::ALPHABET + c.symbol];
          if (!end_seen[scan_node]) begin
            end_seen[scan_node]  = 1'b1;
            first_end[scan_node] = text_pos;
          end
          last_end[scan_node] = text_pos;
          text_pos++;
        end
      end
      default: sticky_err = 1'b1;
    endcase
  endtask

  // Compare results, then predict from accepted commands
  always @(posedge clk_i or negedge rst_ni) begin
    acm_pkg::acm_result_t exp_r;
    if (!rst_ni) begin
      clear_matcher();
      expected_results.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result_o);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_o.pattern_index !== exp_r.pattern_index) begin
            $display("%0t: pattern_index expected %0d actual %0d", $time,
                     exp_r.pattern_index, result_o.pattern_index);
            errors++;
          end
          if (result_o.found !== exp_r.found) begin
            $display("%0t: found expected %0d actual %0d", $time, exp_r.found,
                     result_o.found);
            errors++;
          end
          if (result_o.first_start !== exp_r.first_start) begin
            $display("%0t: first_start expected %0d actual %0d", $time,
                     exp_r.first_start, result_o.first_start);
            errors++;
          end
          if (result_o.last_start !== exp_r.last_start) begin
            $display("%0t: last_start expected %0d actual %0d", $time,
                     exp_r.last_start, result_o.last_start);
            errors++;
          end
          if (result_o.overflow !== exp_r.overflow) begin
            $display("%0t: overflow expected %0d actual %0d", $time, exp_r.overflow,
                     result_o.overflow);
            errors++;
          end
          if (result_o.last_of_run !== exp_r.last_of_run) begin
            $display("%0t: last_of_run expected %0d actual %0d", $time,
                     exp_r.last_of_run, result_o.last_of_run);
            errors++;
          end
        end
      end
      if (start && !busy) apply_command(cmd_i);
      pending = expected_results.size();
    end
  end

endmodule

>>> verif/multi_pattern_first_last_matcher_core_test.sv
// Top of the matcher testbench: clock, reset, command stimulus, watchdog and
// verdict. Depends on acm_pkg, the matcher core and its checker.
`timescale 1ns / 100ps

module multi_pattern_first_last_matcher_core_test;

  localparam int IDLE_LIMIT = 60000;
  localparam int N_ITEMS    = 470;
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  acm_pkg::acm_cmd_t    cmd_i = '0;
  logic                 result_valid_o;
  acm_pkg::acm_result_t result_o;
  int                   errors, pending;
  int                   idle_cycles = 0;
  int                   burst_left = 0;
  int                   sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multi_pattern_first_last_matcher_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o
  );

  multi_pattern_first_last_matcher_core_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o,
    .errors, .pending
  );

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("multi_pattern_first_last_matcher_core: mismatch");
      $finish;
    end
  end

  // One command transaction; bursts, usually with random gaps in between
  task automatic send_cmd(input logic [2:0] op, input logic [4:0] sym);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
    burst_left--;
    start     <= 1'b1;
    cmd_i.op     <= op;
    cmd_i.symbol <= sym;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  // Pick a letter, mostly from a narrow band so patterns hit often
  function automatic logic [4:0] pick_letter(input int base);
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, acm_pkg::ALPHABET - 1));
    return 5'(base + $urandom_range(0, 2));
  endfunction

  task automatic load_pattern(input int len, input int base, input bit wide);
    for (int j = 0; j < len; j++)
      send_cmd(acm_pkg::OP_PAT_LETTER,
               wide ? 5'($urandom_range(0, acm_pkg::ALPHABET - 1)) : pick_letter(base));
    send_cmd(acm_pkg::OP_PAT_CLOSE, 5'($urandom));
  endtask

  initial begin
    int base, n_text, stop_at;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: misordered ops, reserved op codes, bad symbols, empty pattern, letter extremes
    send_cmd(acm_pkg::OP_TEXT, 5'd0);
    send_cmd(acm_pkg::OP_TEXT, acm_pkg::REPORT_SYM);
    send_cmd(acm_pkg::OP_PAT_CLOSE, 5'd0);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd25);
    send_cmd(acm_pkg::OP_PAT_CLOSE, 5'd31);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd0);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd1);
    send_cmd(acm_pkg::OP_PAT_CLOSE, 5'd0);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd26);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd31);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd0);
    send_cmd(acm_pkg::OP_PAT_CLOSE, 5'd0);
    send_cmd(OP_RSVD_5, 5'd3);
    send_cmd(OP_RSVD_6, 5'd0);
    send_cmd(OP_RSVD_7, 5'd31);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd2);
    send_cmd(acm_pkg::OP_BUILD, 5'd0);
    send_cmd(acm_pkg::OP_PAT_LETTER, 5'd0);
    send_cmd(acm_pkg::OP_PAT_CLOSE, 5'd0);
    send_cmd(acm_pkg::OP_BUILD, 5'd0);
    send_cmd(acm_pkg::OP_TEXT, 5'd0);
    send_cmd(acm_pkg::OP_TEXT, 5'd1);
    send_cmd(acm_pkg::OP_TEXT, 5'd25);
    send_cmd(acm_pkg::OP_TEXT, 5'd27);
    send_cmd(acm_pkg::OP_TEXT, 5'd31);
    send_cmd(acm_pkg::OP_TEXT, acm_pkg::REPORT_SYM);
    send_cmd(acm_pkg::OP_TEXT, 5'd0);
    send_cmd(acm_pkg::OP_TEXT, acm_pkg::REPORT_SYM);
    wait_drained();

    // Capacity: overfill the trie and the pattern table
    send_cmd(acm_pkg::OP_CLEAR, 5'd0);
    for (int p = 0; p <= acm_pkg::MAX_PATTERNS; p++) load_pattern(9, 0, 1'b1);
    send_cmd(acm_pkg::OP_BUILD, 5'd0);
    for (int t = 0; t < 12; t++)
      send_cmd(acm_pkg::OP_TEXT, 5'($urandom_range(0, acm_pkg::ALPHABET - 1)));
    send_cmd(acm_pkg::OP_TEXT, acm_pkg::REPORT_SYM);
    wait_drained();

    // Random sessions: well-formed load/build/scan with some noise
    stop_at = N_ITEMS;
    while (sent < stop_at) begin
      send_cmd(acm_pkg::OP_CLEAR, 5'($urandom));
      base = $urandom_range(0, acm_pkg::ALPHABET - 3);
      repeat ($urandom_range(1, 7)) begin
        load_pattern($urandom_range(0, 5), base, 1'b0);
        if ($urandom_range(0, 11) == 0)
          send_cmd(3'($urandom_range(1, 7)), 5'($urandom));
      end
      if ($urandom_range(0, 4) == 0) send_cmd(acm_pkg::OP_PAT_LETTER, pick_letter(base));
      send_cmd(acm_pkg::OP_BUILD, 5'($urandom));
      n_text = $urandom_range(5, 40);
      for (int t = 0; t < n_text; t++) begin
        if ($urandom_range(0, 29) == 0)
          send_cmd(3'($urandom_range(1, 7)), 5'($urandom));
        else if ($urandom_range(0, 12) == 0) send_cmd(acm_pkg::OP_TEXT, acm_pkg::REPORT_SYM);
        else send_cmd(acm_pkg::OP_TEXT, pick_letter(base));
      end
      send_cmd(acm_pkg::OP_TEXT, acm_pkg::REPORT_SYM);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    // Drain and settle
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("multi_pattern_first_last_matcher_core: match");
    end else begin
      $display("multi_pattern_first_last_matcher_core: mismatch");
    end
    $finish;
  end

endmodule

>>> multi_pattern_first_last_matcher_core.f
+incdir+rtl
rtl/acm_pkg.sv
rtl/acm_pos_store.sv
rtl/multi_pattern_first_last_matcher_core.sv
rtl/acm_checker.sv
verif/multi_pattern_first_last_matcher_core_checker.sv
verif/multi_pattern_first_last_matcher_core_test.sv
